/* hdl/boolean_network_next_state_macros.svh */
// Assertion macros for the Boolean network next-state block.
// Included by files that carry concurrent checks; no other dependencies.
`ifndef BOOLEAN_NETWORK_NEXT_STATE_MACROS_SVH
`define BOOLEAN_NETWORK_NEXT_STATE_MACROS_SVH

`ifndef SYNTHESIS
// Check gated off while reset is low
`define BNNS_ASSERT_RST(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) \
        else $error("bnns check failed");
// Check that also holds while reset is low
`define BNNS_ASSERT_ALWAYS(lbl, clk, prop) \
    lbl: assert property (@(posedge clk) (prop)) \
        else $error("bnns check failed");
`else
`define BNNS_ASSERT_RST(lbl, clk, rst_n, prop)
`define BNNS_ASSERT_ALWAYS(lbl, clk, prop)
`endif

`endif

/* hdl/bnns_pkg.sv */
// Shared types and constants for the Boolean network next-state block.
// No dependencies; used by bnns_cfg, bnns_cell and the top level.
package bnns_pkg;

    // Field widths of one beat
    localparam int CMD_W     = 2;
    localparam int NODE_W    = 4;
    localparam int SLOT_W    = 2;
    localparam int SRC_W     = 4;
    localparam int WORD_W    = 16;
    localparam int STATE_W   = 16;
    localparam int S_TDATA_W = 48;
    localparam int M_TDATA_W = 16;

    // Node count limit set by the 16-bit state vector
    localparam int MAX_NODES = 16;

    // Configuration widths
    localparam int ACT_W     = 5;
    localparam int LCNT_W    = 3;
    localparam int CFG_W     = 5;
    localparam int CFG_IDX_W = 1;

    // Command codes carried in tuser
    typedef enum logic [CMD_W-1:0] {
        CMD_LINK  = 2'd0,
        CMD_TABLE = 2'd1,
        CMD_EVAL  = 2'd2
    } t_cmd;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NODES = 1'd0,
        REG_LINKS = 1'd1
    } t_reg;

    // Saturated configuration seen by the cells
    typedef struct packed {
        logic [ACT_W-1:0]   n_act;
        logic [LCNT_W-1:0]  k_shift;
        logic [STATE_W-1:0] state_mask;
    } t_cfg;

    // One beat travelling down the cell chain
    typedef struct packed {
        logic               valid;
        t_cmd               cmd;
        logic [NODE_W-1:0]  node;
        logic [SLOT_W-1:0]  slot;
        logic [SRC_W-1:0]   src;
        logic [WORD_W-1:0]  word;
        logic [STATE_W-1:0] state;
        logic [STATE_W-1:0] next;
    } t_beat;

endpackage

/* hdl/bnns_cfg.sv */
// Configuration registers with saturation of node and link counts.
// Depends on bnns_pkg.
module bnns_cfg #(
    parameter int NODES = 16,
    parameter int LINKS = 4
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bnns_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bnns_pkg::CFG_W-1:0]   i_cfg_data,
    output bnns_pkg::t_cfg               o_cfg
);
    import bnns_pkg::*;

    localparam int CELLS = (NODES > MAX_NODES) ? MAX_NODES : NODES;

    logic [ACT_W-1:0]  r_nodes;
    logic [LCNT_W-1:0] r_links;
    logic [ACT_W-1:0]  w_n_act;
    logic [LCNT_W-1:0] w_k_act;

    // Register writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_nodes <= ACT_W'(MAX_NODES);
            r_links <= LCNT_W'(4);
        end else if (i_cfg_we) begin
            case (t_reg'(i_cfg_idx))
                REG_NODES: r_nodes <= i_cfg_data[ACT_W-1:0];
                REG_LINKS: r_links <= i_cfg_data[LCNT_W-1:0];
                default: ;
            endcase
        end
    end

    // Clamp counts to the built hardware
    always_comb begin
        w_n_act = (r_nodes > ACT_W'(CELLS)) ? ACT_W'(CELLS) : r_nodes;
        w_k_act = (r_links > LCNT_W'(LINKS)) ? LCNT_W'(LINKS) : r_links;
    end

    // Active-node mask and index shift
    always_comb begin
        o_cfg.n_act   = w_n_act;
        o_cfg.k_shift = LCNT_W'(LINKS) - w_k_act;
        for (int b = 0; b < STATE_W; b++) begin
            o_cfg.state_mask[b] = (ACT_W'(b) < w_n_act);
        end
    end

endmodule

/* hdl/bnns_cell.sv */
// One node cell: holds the node's links and truth table, applies writes
// addressed to it and sets its bit of the next state. Depends on bnns_pkg.
module bnns_cell #(
    parameter int NODE  = 0,
    parameter int LINKS = 4
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_en,
    input  bnns_pkg::t_cfg  i_cfg,
    input  bnns_pkg::t_beat i_beat,
    output bnns_pkg::t_beat o_beat
);
    import bnns_pkg::*;

    localparam int TBL_W  = ((1 << LINKS) > WORD_W) ? (1 << LINKS) : WORD_W;
    localparam int TIDX_W = $clog2(TBL_W);

    logic [SRC_W-1:0]  r_link [LINKS];
    logic [WORD_W-1:0] r_table;
    t_beat             r_beat;
    t_beat             n_beat;

    logic              w_hit;
    logic [LINKS-1:0]  w_idx_full;
    logic [LINKS-1:0]  w_idx;
    logic [TIDX_W-1:0] w_tidx;
    logic [TBL_W-1:0]  w_tbl;
    logic              w_bit;

    assign w_hit = i_en && i_beat.valid && (32'(i_beat.node) == NODE);

    // Link and table writes addressed to this node
    always_ff @(posedge i_clk) begin
        if (w_hit && (i_beat.cmd == CMD_LINK)) begin
            for (int j = 0; j < LINKS; j++) begin
                if (32'(i_beat.slot) == j) begin
                    r_link[j] <= i_beat.src;
                end
            end
        end
        if (w_hit && (i_beat.cmd == CMD_TABLE)) begin
            r_table <= i_beat.word;
        end
    end

    // Gather linked bits, link 0 most significant, then drop unused links
    always_comb begin
        for (int j = 0; j < LINKS; j++) begin
            w_idx_full[LINKS-1-j] = i_beat.state[r_link[j]];
        end
        w_idx  = w_idx_full >> i_cfg.k_shift;
        w_tidx = TIDX_W'(w_idx);
        w_tbl  = TBL_W'(r_table);
        w_bit  = w_tbl[w_tidx];
    end

    // Pass the beat on, adding this node's next-state bit
    always_comb begin
        n_beat = i_beat;
        if ((i_beat.cmd == CMD_EVAL) && (ACT_W'(NODE) < i_cfg.n_act)) begin
            n_beat.next[NODE] = w_bit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_beat.valid <= 1'b0;
        end else if (i_en) begin
            r_beat <= n_beat;
        end
    end

    assign o_beat = r_beat;

endmodule

/* hdl/boolean_network_next_state.sv */
// A beat is registered in each node cell on its way from input to result;
// throughput one beat per cycle while no result is stalled at the output, set by the row of node cells.
// Write beats travel the chain too and update a node's cell as they pass it.
// Reset (synchronous, active low) clears beat valids, holds the input not ready
// and sets nodes_in_use to 16 and links_in_use to 4; links and truth tables
// hold nothing until written.
`include "boolean_network_next_state_macros.svh"

module boolean_network_next_state #(
    parameter int NODES = 16,
    parameter int LINKS = 4
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // Input stream
    input  logic                           i_s_tvalid,
    output logic                           o_s_tready,
    // [3:0] node_index, [5:4] link_slot, [9:6] source_node,
    // [25:10] table_word, [41:26] state_vector, [47:42] zero
    input  logic [bnns_pkg::S_TDATA_W-1:0] i_s_tdata,
    // [1:0] command
    input  logic [bnns_pkg::CMD_W-1:0]     i_s_tuser,
    // Result stream
    output logic                           o_m_tvalid,
    input  logic                           i_m_tready,
    // [15:0] next_state
    output logic [bnns_pkg::M_TDATA_W-1:0] o_m_tdata,
    // Configuration writes
    input  logic                           i_cfg_we,
    input  logic [bnns_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  logic [bnns_pkg::CFG_W-1:0]     i_cfg_data
);
    import bnns_pkg::*;

    localparam int CELLS = (NODES > MAX_NODES) ? MAX_NODES : NODES;

    t_cfg  w_cfg;
    t_beat w_beat [CELLS+1];
    logic  w_en;

    bnns_cfg #(
        .NODES (NODES),
        .LINKS (LINKS)
    ) u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (w_cfg)
    );

    // Whole chain advances unless a result is stalled at the output
    assign w_en       = !(o_m_tvalid && !i_m_tready);
    assign o_s_tready = w_en && i_rst_n;

    // Unpack the input beat; inactive nodes read as zero
    always_comb begin
        w_beat[0].valid = i_s_tvalid && i_rst_n;
        w_beat[0].cmd   = t_cmd'(i_s_tuser);
        w_beat[0].node  = i_s_tdata[3:0];
        w_beat[0].slot  = i_s_tdata[5:4];
        w_beat[0].src   = i_s_tdata[9:6];
        w_beat[0].word  = i_s_tdata[25:10];
        w_beat[0].state = i_s_tdata[41:26] & w_cfg.state_mask;
        w_beat[0].next  = '0;
    end

    // Row of node cells
    for (genvar g = 0; g < CELLS; g++) begin : g_cell
        bnns_cell #(
            .NODE  (g),
            .LINKS (LINKS)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_en    (w_en),
            .i_cfg   (w_cfg),
            .i_beat  (w_beat[g]),
            .o_beat  (w_beat[g+1])
        );
    end

    // Only evaluate beats produce a result; writes drop off the end
    assign o_m_tvalid = w_beat[CELLS].valid && (w_beat[CELLS].cmd == CMD_EVAL);
    assign o_m_tdata  = w_beat[CELLS].next;

    // Checks
    `BNNS_ASSERT_ALWAYS(a_rst_no_result, i_clk, !i_rst_n |=> !o_m_tvalid)
    `BNNS_ASSERT_RST(a_inactive_zero, i_clk, i_rst_n, o_m_tvalid |-> ((o_m_tdata & ~w_cfg.state_mask) == '0))
    `BNNS_ASSERT_RST(a_chain_holds, i_clk, i_rst_n, (o_m_tvalid && !i_m_tready) |=> $stable(w_beat[CELLS]))

endmodule
